### sv/prt_pkg.sv
// Package for the prefix reordering tokenizer: token word type, character codes,
// character classes and depth limits. No dependencies.
package prt_pkg;

   // Text and depth limits
   localparam int TEXT_LIMIT = 65536;
   localparam int POS_W      = 16;
   localparam int LEN_W      = 17;
   localparam int DEPTH_BITS = 8;

   localparam logic [POS_W-1:0] POS_MAX   = POS_W'(TEXT_LIMIT - 1);
   localparam logic [LEN_W-1:0] LEN_MAX   = LEN_W'(TEXT_LIMIT);
   localparam logic signed [DEPTH_BITS-1:0] DEPTH_MAX = DEPTH_BITS'((1 << (DEPTH_BITS - 1)) - 1);
   localparam logic signed [DEPTH_BITS-1:0] DEPTH_MIN = DEPTH_BITS'(-(1 << (DEPTH_BITS - 1)));

   // Output queue depth
   localparam int QDEPTH = 6;
   localparam int QCNT_W = 3;

   // Character codes
   localparam logic [7:0] CHR_NUL    = 8'h00;
   localparam logic [7:0] CHR_QUOTE  = 8'h22;
   localparam logic [7:0] CHR_LPAREN = 8'h28;
   localparam logic [7:0] CHR_RPAREN = 8'h29;
   localparam logic [7:0] CHR_STAR   = 8'h2A;
   localparam logic [7:0] CHR_PLUS   = 8'h2B;
   localparam logic [7:0] CHR_MINUS  = 8'h2D;
   localparam logic [7:0] CHR_SLASH  = 8'h2F;
   localparam logic [7:0] CHR_COLON  = 8'h3A;
   localparam logic [7:0] CHR_AT     = 8'h40;
   localparam logic [7:0] CHR_LBRACE = 8'h7B;
   localparam logic [7:0] CHR_RBRACE = 8'h7D;

   // Token kinds
   localparam logic KIND_LITERAL = 1'b0;
   localparam logic KIND_EXPR    = 1'b1;

   // Character class, also the class of the open run
   typedef enum logic [1:0] {
      CLS_NONE  = 2'd0,
      CLS_DIGIT = 2'd1,
      CLS_ALPHA = 2'd2,
      CLS_QUOTE = 2'd3
   } class_type;

   // One result word
   typedef struct packed {
      logic                         kind;
      logic [POS_W-1:0]             start;
      logic [LEN_W-1:0]             length;
      logic signed [DEPTH_BITS-1:0] depth;
      logic                         missing;
      logic                         eot;
   } token_type;

   // Words handed from the core to the output queue in one cycle
   typedef struct packed {
      logic [1:0] num;
      token_type  tok0;
      token_type  tok1;
   } push_type;

   function automatic class_type class_of(input logic [7:0] c);
      class_type cls;
      cls = CLS_NONE;
      if (c inside {[8'h30:8'h39]}) begin
         cls = CLS_DIGIT;
      end else if (c inside {[8'h41:8'h5A], [8'h61:8'h7A]}) begin
         cls = CLS_ALPHA;
      end else if (c == CHR_QUOTE) begin
         cls = CLS_QUOTE;
      end
      return cls;
   endfunction

endpackage

### sv/prefix_reordering_tokenizer_top.sv
// Top level of the prefix reordering tokenizer: core plus output queue.
// Depends on prt_pkg, prt_core and prt_queue.
//
//   channel | direction | handshake             | word
//   req     | in        | req_valid / req_ready | req_character
//   rsp     | out       | rsp_valid / rsp_ready | rsp_token_kind .. rsp_end_of_text
//
// A character is registered on accept and worked on in the next cycle; its
// results (zero, one or two words) enter a six-word output queue, so the first
// word can be taken once it has passed the input register and the queue register.
// Sustained rate is one character per cycle while the result side takes one word
// per cycle; the queue drains one word a cycle, which bounds steps that make two.
// req_ready falls when the queue lacks room for two words beyond the one in flight.
// Reset is synchronous, active high, and clears all control and text state.
module prefix_reordering_tokenizer_top (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic [7:0]        req_character,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic              rsp_token_kind,
   output logic [15:0]       rsp_token_start,
   output logic [16:0]       rsp_token_length,
   output logic signed [7:0] rsp_nesting_depth,
   output logic              rsp_missing_operand,
   output logic              rsp_end_of_text
);

   prt_pkg::push_type          push;
   prt_pkg::token_type         head;
   logic [prt_pkg::QCNT_W-1:0] count;

   prt_core u_core (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_character (req_character),
      .count         (count),
      .push          (push)
   );

   prt_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .count     (count),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .head      (head)
   );

   // result word fields
   assign rsp_token_kind      = head.kind;
   assign rsp_token_start     = head.start;
   assign rsp_token_length    = head.length;
   assign rsp_nesting_depth   = head.depth;
   assign rsp_missing_operand = head.missing;
   assign rsp_end_of_text     = head.eot;

endmodule

### sv/prt_queue.sv
// Output queue of the tokenizer: a shift queue of result words, up to two
// written per cycle, one read per cycle at the head. Depends on prt_pkg.
module prt_queue (
   input  logic                       clock,
   input  logic                       reset,
   input  prt_pkg::push_type          push,
   output logic [prt_pkg::QCNT_W-1:0] count,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output prt_pkg::token_type         head
);

   prt_pkg::token_type               q_ff [prt_pkg::QDEPTH];
   prt_pkg::token_type               q_in [prt_pkg::QDEPTH];
   logic [prt_pkg::QCNT_W-1:0]       count_ff, count_in;
   logic [prt_pkg::QCNT_W-1:0]       base;
   logic                             pop;

   assign pop       = rsp_valid && rsp_ready;
   assign rsp_valid = (count_ff != '0);
   assign head      = q_ff[0];
   assign count     = count_ff;
   assign base      = count_ff - prt_pkg::QCNT_W'(pop);

   // shift on pop, then append new words behind the survivors
   always_comb begin
      for (int i = 0; i < prt_pkg::QDEPTH; i++) begin
         if (pop && (i < prt_pkg::QDEPTH - 1)) begin
            q_in[i] = q_ff[i + 1];
         end else begin
            q_in[i] = q_ff[i];
         end
         if ((push.num != 2'd0) && (prt_pkg::QCNT_W'(i) == base)) begin
            q_in[i] = push.tok0;
         end
         if ((push.num == 2'd2) && (prt_pkg::QCNT_W'(i) == base + 1'b1)) begin
            q_in[i] = push.tok1;
         end
      end
      count_in = base + prt_pkg::QCNT_W'(push.num);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < prt_pkg::QDEPTH; i++) begin
         q_ff[i] <= q_in[i];
      end
   end

   // fill level stays within the queue
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= prt_pkg::QCNT_W'(prt_pkg::QDEPTH))
      else $error("output queue count out of range");

   // pushes never overrun the queue
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      ({1'b0, base} + {2'b00, push.num}) <= (prt_pkg::QCNT_W + 1)'(prt_pkg::QDEPTH))
      else $error("output queue overflow");

   // count follows pushes and pops
   a_count_track: assert property (@(posedge clock) disable iff (reset)
      1'b1 |=> count_ff == $past(count_ff) - prt_pkg::QCNT_W'($past(pop))
                           + prt_pkg::QCNT_W'($past(push.num)))
      else $error("output queue count mismatch");

endmodule

### sv/prt_core.sv
// Tokenizer core: input register, run and nesting state, held token and the
// prefix reordering; hands up to two words per cycle to the queue. Depends on prt_pkg.
module prt_core (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic [7:0]                 req_character,
   input  logic [prt_pkg::QCNT_W-1:0] count,
   output prt_pkg::push_type          push
);

   localparam int PW = prt_pkg::POS_W;
   localparam int LW = prt_pkg::LEN_W;
   localparam int DW = prt_pkg::DEPTH_BITS;

   // input register
   logic       s1_valid_ff;
   logic [7:0] s1_char_ff;

   // tokenizer state
   logic [PW-1:0]           position_ff, position_in;
   prt_pkg::class_type      run_class_ff, run_class_in;
   logic [PW-1:0]           run_start_ff, run_start_in;
   logic [LW-1:0]           run_length_ff, run_length_in;
   logic signed [DW-1:0]    depth_ff, depth_in;
   logic                    held_valid_ff, held_valid_in;
   prt_pkg::token_type      held_ff, held_in;

   logic                    accept;
   prt_pkg::class_type      cls;
   prt_pkg::token_type      tok0, tok1, run_tok, chr_tok;
   logic [1:0]              emit_num;
   logic                    done;
   logic signed [DW-1:0]    depth_up, depth_dn;

   // room for this word's results plus the one in the input register
   assign req_ready = !reset
                      && (({1'b0, count} + (s1_valid_ff ? 4'd2 : 4'd0))
                          <= (prt_pkg::QCNT_W + 1)'(prt_pkg::QDEPTH - 2));
   assign accept    = req_valid && req_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_char_ff <= req_character;
      end
   end

   assign cls      = prt_pkg::class_of(s1_char_ff);
   assign depth_up = (depth_ff == prt_pkg::DEPTH_MAX) ? depth_ff : depth_ff + DW'(1);
   assign depth_dn = (depth_ff == prt_pkg::DEPTH_MIN) ? depth_ff : depth_ff - DW'(1);

   // one character step
   always_comb begin
      position_in   = position_ff;
      run_class_in  = run_class_ff;
      run_start_in  = run_start_ff;
      run_length_in = run_length_ff;
      depth_in      = depth_ff;
      held_valid_in = held_valid_ff;
      held_in       = held_ff;
      tok0          = '0;
      tok1          = '0;
      run_tok       = '0;
      emit_num      = 2'd0;
      done          = 1'b0;

      chr_tok         = '0;
      chr_tok.kind    = prt_pkg::KIND_EXPR;
      chr_tok.start   = position_ff;
      chr_tok.length  = LW'(1);
      chr_tok.depth   = depth_ff;

      if (s1_valid_ff) begin
         if (position_ff != prt_pkg::POS_MAX) begin
            position_in = position_ff + 1'b1;
         end

         // extend an open run
         if (run_class_ff == prt_pkg::CLS_QUOTE && s1_char_ff != prt_pkg::CHR_NUL) begin
            if (run_length_ff != prt_pkg::LEN_MAX) begin
               run_length_in = run_length_ff + 1'b1;
            end
            done = 1'b1;
         end else if (run_class_ff != prt_pkg::CLS_NONE && cls == run_class_ff) begin
            if (run_length_ff != prt_pkg::LEN_MAX) begin
               run_length_in = run_length_ff + 1'b1;
            end
            done = 1'b1;
         end

         // close the run: a closing quote, a class change or end of text
         run_tok.kind   = prt_pkg::KIND_LITERAL;
         run_tok.start  = run_start_ff;
         run_tok.length = run_length_in;
         run_tok.depth  = depth_ff;
         if ((run_class_ff == prt_pkg::CLS_QUOTE && s1_char_ff == prt_pkg::CHR_QUOTE)
             || (run_class_ff != prt_pkg::CLS_NONE && !done)) begin
            if (held_valid_ff) begin
               tok0     = held_ff;
               emit_num = 2'd1;
            end
            held_in       = run_tok;
            held_valid_in = 1'b1;
            run_class_in  = prt_pkg::CLS_NONE;
         end

         if (!done) begin
            if (s1_char_ff == prt_pkg::CHR_NUL) begin
               // flush the held word and restart the text
               if (held_valid_in) begin
                  if (emit_num == 2'd0) begin
                     tok0     = held_in;
                     tok0.eot = 1'b1;
                  end else begin
                     tok1     = held_in;
                     tok1.eot = 1'b1;
                  end
                  emit_num = emit_num + 2'd1;
               end
               position_in   = '0;
               run_class_in  = prt_pkg::CLS_NONE;
               run_start_in  = '0;
               run_length_in = '0;
               depth_in      = '0;
               held_valid_in = 1'b0;
               held_in       = '0;
            end else if (cls != prt_pkg::CLS_NONE) begin
               run_class_in  = cls;
               run_start_in  = position_ff;
               run_length_in = LW'(1);
            end else begin
               case (s1_char_ff)
                  prt_pkg::CHR_LPAREN, prt_pkg::CHR_LBRACE: begin
                     if (held_valid_in) begin
                        if (emit_num == 2'd0) begin
                           tok0 = held_in;
                        end else begin
                           tok1 = held_in;
                        end
                        emit_num = emit_num + 2'd1;
                     end
                     held_in       = chr_tok;
                     held_valid_in = 1'b1;
                     depth_in      = depth_up;
                  end
                  prt_pkg::CHR_RPAREN, prt_pkg::CHR_RBRACE: begin
                     depth_in = depth_dn;
                  end
                  prt_pkg::CHR_PLUS, prt_pkg::CHR_MINUS, prt_pkg::CHR_STAR,
                  prt_pkg::CHR_SLASH, prt_pkg::CHR_AT, prt_pkg::CHR_COLON: begin
                     // operator first, operand sinks a level; if none, held as missing
                     if (held_valid_in) begin
                        if (emit_num == 2'd0) begin
                           tok0 = chr_tok;
                        end else begin
                           tok1 = chr_tok;
                        end
                        emit_num      = emit_num + 2'd1;
                        held_in.depth = depth_up;
                     end else begin
                        held_in         = chr_tok;
                        held_in.missing = 1'b1;
                        held_valid_in   = 1'b1;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
      end
   end

   assign push.num  = emit_num;
   assign push.tok0 = tok0;
   assign push.tok1 = tok1;

   always_ff @(posedge clock) begin
      if (reset) begin
         position_ff   <= '0;
         run_class_ff  <= prt_pkg::CLS_NONE;
         run_start_ff  <= '0;
         run_length_ff <= '0;
         depth_ff      <= '0;
         held_valid_ff <= 1'b0;
         held_ff       <= '0;
      end else begin
         position_ff   <= position_in;
         run_class_ff  <= run_class_in;
         run_start_ff  <= run_start_in;
         run_length_ff <= run_length_in;
         depth_ff      <= depth_in;
         held_valid_ff <= held_valid_in;
         held_ff       <= held_in;
      end
   end

   // end of text returns the core to its reset state
   a_nul_restart: assert property (@(posedge clock) disable iff (reset)
      (s1_valid_ff && s1_char_ff == prt_pkg::CHR_NUL)
      |=> (position_ff == '0 && !held_valid_ff && run_class_ff == prt_pkg::CLS_NONE))
      else $error("core not cleared after end of text");

   // the end mark rides only on words caused by NUL
   a_eot_on_nul: assert property (@(posedge clock) disable iff (reset)
      ((emit_num != 2'd0 && tok0.eot) || (emit_num == 2'd2 && tok1.eot))
      |-> (s1_valid_ff && s1_char_ff == prt_pkg::CHR_NUL))
      else $error("end of text mark without NUL");

   // nothing is produced without a character in the input register
   a_emit_needs_item: assert property (@(posedge clock) disable iff (reset)
      (emit_num != 2'd0) |-> s1_valid_ff)
      else $error("word emitted with no character");

endmodule
